// File: rtl/core/rtt_pkg.sv
`timescale 1ns / 1ps

package rtt_pkg;

    // ring of send times, one slot per frame id modulo the depth
    localparam int HIST_DEPTH = 64;
    localparam int HIST_IDX_W = $clog2(HIST_DEPTH);

    // round trips at or above this many ms are rejected
    localparam logic [31:0] RTT_LIMIT_MS = 32'd2000;

    // alpha scale, one in units of 1/256
    localparam logic [8:0] ALPHA_ONE   = 9'd256;
    localparam logic [8:0] ALPHA_RESET = 9'd32;

    // command codes
    typedef enum logic [1:0] {
        CMD_SEND = 2'd0,
        CMD_ACK  = 2'd1,
        CMD_SET  = 2'd2
    } t_cmd;

    // sample status codes
    typedef enum logic [1:0] {
        STAT_NONE   = 2'd0,
        STAT_OK     = 2'd1,
        STAT_REJECT = 2'd2
    } t_status;

    // command word
    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] cmd_id;
        logic [31:0] now_ms;
    } t_cmd_word;

    // result word
    typedef struct packed {
        logic [31:0] assigned_frame_id;
        logic [18:0] smoothed_rtt;
        logic [1:0]  sample_status;
    } t_result_word;

endpackage

// File: rtl/core/rtt_ram.sv
`timescale 1ns / 1ps

module rtt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/rtt_ema_tracker_unit.sv
`timescale 1ns / 1ps

// Round-trip-time tracker with an exponential moving average.
// Command channel: a word (command, cmd_id, now_ms) is taken on a rising edge
// with start high and busy low. Send bumps the frame counter and stamps now_ms
// into the ring slot of the new id; ack looks up the slot of cmd_id, measures
// the round trip and folds it into the average; set loads the frame counter.
// Result channel: one result word per command on o_result, marked by o_valid high
// for exactly one cycle; the receiver cannot stall, so results never back up.
// Timing: send, set and unused codes give their result the cycle
// after acceptance and keep busy low, so one word per cycle. An ack holds busy
// through S_CHECK, where the registered ring read is checked, and, when an
// average is blended, through S_BLEND for the multiply, before its result.
// Config: i_cfg_we/i_cfg_data write ema_alpha (values above 256 act as 256);
// write only while idle.
// Reset: synchronous, active low. Frame counter and average go to zero, alpha
// to 32, and the ring slots are marked empty through per-slot valid flops, so
// the block is ready in the first cycle after reset.
module rtt_ema_tracker_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  rtt_pkg::t_cmd_word    i_cmd,
    output logic                  o_valid,
    output rtt_pkg::t_result_word o_result,
    input  logic                  i_cfg_we,
    input  logic [8:0]            i_cfg_data
);

    import rtt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_BLEND
    } t_state;

    t_state                  r_state;
    logic                    r_valid;
    t_result_word            r_result;
    logic [31:0]             r_counter;
    logic [19:0]             r_avg;
    logic [8:0]              r_alpha;
    logic [HIST_DEPTH-1:0]   r_slot_vld;
    logic [HIST_IDX_W-1:0]   r_idx;
    logic [31:0]             r_now;
    logic signed [20:0]      r_delta;

    logic                    accept;
    logic [31:0]             cnt_inc;
    logic                    ram_we;
    logic [HIST_IDX_W-1:0]   ram_waddr;
    logic [HIST_IDX_W-1:0]   ram_raddr;
    logic [31:0]             ram_rdata;

    logic [31:0]             sent;
    logic [31:0]             rtt;
    logic                    sample_ok;
    logic [19:0]             sample_fx;
    logic signed [20:0]      n_delta;
    logic signed [30:0]      prod;
    logic signed [31:0]      blend_sum;
    logic [19:0]             n_avg;

    assign accept  = start && (r_state == S_IDLE);
    assign cnt_inc = r_counter + 32'd1;

    // ring write on send, read address always from the incoming id
    assign ram_we    = accept && (i_cmd.command == CMD_SEND);
    assign ram_waddr = cnt_inc[HIST_IDX_W-1:0];
    assign ram_raddr = i_cmd.cmd_id[HIST_IDX_W-1:0];

    rtt_ram #(
        .WIDTH (32),
        .DEPTH (HIST_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_cmd.now_ms),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // slot check: empty slots read as zero
    always_comb begin
        sent      = r_slot_vld[r_idx] ? ram_rdata : 32'd0;
        rtt       = r_now - sent;
        sample_ok = (r_now >= sent) && (rtt != 32'd0) && (rtt < RTT_LIMIT_MS);
        sample_fx = {1'b0, rtt[10:0], 8'd0};
        n_delta   = $signed({1'b0, sample_fx}) - $signed({1'b0, r_avg});
    end

    // blend: (256*v + a*(s - v) + 128) >> 8
    always_comb begin
        prod      = $signed({1'b0, r_alpha}) * r_delta;
        blend_sum = $signed({4'd0, r_avg, 8'd0}) + $signed({prod[30], prod})
                    + $signed(32'd128);
        n_avg     = blend_sum[27:8];
    end

    // sequencer, state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= 1'b0;
            r_counter  <= 32'd0;
            r_avg      <= 20'd0;
            r_alpha    <= ALPHA_RESET;
            r_slot_vld <= '0;
        end else begin
            r_valid <= 1'b0;

            if (i_cfg_we) begin
                r_alpha <= (i_cfg_data > ALPHA_ONE) ? ALPHA_ONE : i_cfg_data;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_cmd.command)
                            CMD_SEND: begin
                                r_counter                     <= cnt_inc;
                                r_slot_vld[ram_waddr]         <= 1'b1;
                                r_valid                       <= 1'b1;
                                r_result.assigned_frame_id    <= cnt_inc;
                                r_result.smoothed_rtt         <= r_avg[18:0];
                                r_result.sample_status        <= STAT_NONE;
                            end
                            CMD_ACK: begin
                                r_idx   <= ram_raddr;
                                r_now   <= i_cmd.now_ms;
                                r_state <= S_CHECK;
                            end
                            CMD_SET: begin
                                r_counter                     <= i_cmd.cmd_id;
                                r_valid                       <= 1'b1;
                                r_result.assigned_frame_id    <= i_cmd.cmd_id;
                                r_result.smoothed_rtt         <= r_avg[18:0];
                                r_result.sample_status        <= STAT_NONE;
                            end
                            default: begin
                                r_valid                       <= 1'b1;
                                r_result.assigned_frame_id    <= r_counter;
                                r_result.smoothed_rtt         <= r_avg[18:0];
                                r_result.sample_status        <= STAT_NONE;
                            end
                        endcase
                    end
                end
                S_CHECK: begin
                    r_result.assigned_frame_id <= r_counter;
                    if (sent == 32'd0) begin
                        r_valid                <= 1'b1;
                        r_result.smoothed_rtt  <= r_avg[18:0];
                        r_result.sample_status <= STAT_NONE;
                        r_state                <= S_IDLE;
                    end else begin
                        // any read of a stamped slot empties it
                        r_slot_vld[r_idx] <= 1'b0;
                        if (!sample_ok) begin
                            r_valid                <= 1'b1;
                            r_result.smoothed_rtt  <= r_avg[18:0];
                            r_result.sample_status <= STAT_REJECT;
                            r_state                <= S_IDLE;
                        end else if (r_avg == 20'd0) begin
                            // first sample loads the average
                            r_avg                  <= sample_fx;
                            r_valid                <= 1'b1;
                            r_result.smoothed_rtt  <= sample_fx[18:0];
                            r_result.sample_status <= STAT_OK;
                            r_state                <= S_IDLE;
                        end else begin
                            r_delta <= n_delta;
                            r_state <= S_BLEND;
                        end
                    end
                end
                S_BLEND: begin
                    r_avg                  <= n_avg;
                    r_valid                <= 1'b1;
                    r_result.smoothed_rtt  <= n_avg[18:0];
                    r_result.sample_status <= STAT_OK;
                    r_state                <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
